>>> hdl/lcd_rectangle_fill_sequencer_defines.svh
// Assertion macros shared by the window fill sequencer modules.
`ifndef LCD_RECTANGLE_FILL_SEQUENCER_DEFINES_SVH
`define LCD_RECTANGLE_FILL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrfs assertion failed");

// Next-cycle implication, checked outside reset.
`define LRFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrfs assertion failed");

`endif

>>> hdl/lrfs_pkg.sv
// Types and constants of the window fill sequencer.
package lrfs_pkg;

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	localparam logic [1:0] ORIENT_PORTRAIT  = 2'd0;
	localparam logic [1:0] ORIENT_LANDSCAPE = 2'd1;

	localparam logic [7:0] FIXED_MARK = 8'h01;

	// Header byte positions; odd positions carry the 0x00 half of a word.
	localparam logic [4:0] STEP_COL_CMD    = 5'd0;
	localparam logic [4:0] STEP_COL_START  = 5'd2;
	localparam logic [4:0] STEP_COL_MARK0  = 5'd4;
	localparam logic [4:0] STEP_COL_END    = 5'd6;
	localparam logic [4:0] STEP_COL_MARK1  = 5'd8;
	localparam logic [4:0] STEP_PAGE_CMD   = 5'd10;
	localparam logic [4:0] STEP_PAGE_START = 5'd12;
	localparam logic [4:0] STEP_PAGE_END   = 5'd14;
	localparam logic [4:0] STEP_RAMWR      = 5'd16;
	localparam logic [4:0] STEP_PIXELS     = 5'd18;

	typedef enum logic [2:0] {
		REG_COLUMN_SET_CODE = 3'd0,
		REG_PAGE_SET_CODE   = 3'd1,
		REG_RAM_WRITE_CODE  = 3'd2,
		REG_COLUMN_OFFSET   = 3'd3,
		REG_PANEL_COLUMNS   = 3'd4
	} reg_index_t;

	localparam logic [7:0] RST_COLUMN_SET_CODE = 8'd21;
	localparam logic [7:0] RST_PAGE_SET_CODE   = 8'd117;
	localparam logic [7:0] RST_RAM_WRITE_CODE  = 8'd92;
	localparam logic [7:0] RST_COLUMN_OFFSET   = 8'd8;
	localparam logic [7:0] RST_PANEL_COLUMNS   = 8'd132;

	typedef struct packed {
		logic [7:0] column_set_code;
		logic [7:0] page_set_code;
		logic [7:0] ram_write_code;
		logic [7:0] column_offset;
		logic [7:0] panel_columns;
	} cfg_t;

	typedef struct packed {
		logic [7:0] serial_byte;
		logic       is_command;
		logic       frame_end;
	} result_t;

endpackage

>>> hdl/lcd_rectangle_fill_sequencer.sv
// Top level of the LCD window fill command sequencer.
// A tick's byte goes to the head register, or to the skid register on a stall.
// Throughput: one word in per cycle; the two-word output buffer keeps input open
// while one finished byte waits, and closes it only when both entries are full.
// Reset (arst_n low) clears the busy flag, counters and buffer, and loads the
// command codes, column offset and panel column count with their defaults.
module lcd_rectangle_fill_sequencer #(
	parameter int COORD_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  box_width,
	input  logic [7:0]  box_height,
	input  logic [15:0] fill_color,
	input  logic [1:0]  orientation,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  serial_byte,
	output logic        is_command,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	lrfs_pkg::cfg_t    cfg;
	lrfs_pkg::result_t res;
	lrfs_pkg::result_t out_word;
	logic              res_valid;
	logic              in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;

	lrfs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lrfs_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.box_width   (box_width),
		.box_height  (box_height),
		.fill_color  (fill_color),
		.orientation (orientation),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	lrfs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_word)
	);

	assign serial_byte = out_word.serial_byte;
	assign is_command  = out_word.is_command;
	assign frame_end   = out_word.frame_end;

endmodule

>>> hdl/lrfs_cfg_regs.sv
// Configuration register file of the window fill sequencer.
module lrfs_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [7:0]        wr_data,
	output lrfs_pkg::cfg_t    cfg
);

	lrfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_set_code <= lrfs_pkg::RST_COLUMN_SET_CODE;
			cfg_q.page_set_code   <= lrfs_pkg::RST_PAGE_SET_CODE;
			cfg_q.ram_write_code  <= lrfs_pkg::RST_RAM_WRITE_CODE;
			cfg_q.column_offset   <= lrfs_pkg::RST_COLUMN_OFFSET;
			cfg_q.panel_columns   <= lrfs_pkg::RST_PANEL_COLUMNS;
		end else if (wr_en) begin
			case (wr_index)
				lrfs_pkg::REG_COLUMN_SET_CODE: cfg_q.column_set_code <= wr_data;
				lrfs_pkg::REG_PAGE_SET_CODE:   cfg_q.page_set_code   <= wr_data;
				lrfs_pkg::REG_RAM_WRITE_CODE:  cfg_q.ram_write_code  <= wr_data;
				lrfs_pkg::REG_COLUMN_OFFSET:   cfg_q.column_offset   <= wr_data;
				lrfs_pkg::REG_PANEL_COLUMNS:   cfg_q.panel_columns   <= wr_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/lrfs_core.sv
// Request latch, header and pixel counters, and per-tick byte selection.
`include "lcd_rectangle_fill_sequencer_defines.svh"

module lrfs_core #(
	parameter int COORD_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 mode,
	input  logic [7:0]           pos_x,
	input  logic [7:0]           pos_y,
	input  logic [7:0]           box_width,
	input  logic [7:0]           box_height,
	input  logic [15:0]          fill_color,
	input  logic [1:0]           orientation,
	input  lrfs_pkg::cfg_t       cfg,
	output logic                 res_valid,
	output lrfs_pkg::result_t    res
);

	localparam int CW = COORD_BITS;

	logic          busy_q;
	logic [4:0]    header_step_q;
	logic [15:0]   pixels_left_q;
	logic          low_byte_next_q;
	logic [CW-1:0] window_q [4];
	logic [15:0]   held_color_q;

	logic          req;
	logic          in_header;
	logic [15:0]   pixels_dec;
	logic [CW-1:0] x_w, y_w, w_w, h_w, off_w, cols_w, one_w;
	logic [CW-1:0] win_new [4];

	assign req       = in_fire && (mode == lrfs_pkg::MODE_REQUEST) && !busy_q;
	assign res_valid = in_fire && (mode == lrfs_pkg::MODE_TICK) && busy_q;
	assign in_header = header_step_q < lrfs_pkg::STEP_PIXELS;
	assign pixels_dec = pixels_left_q - ((pixels_left_q != 16'd0) ? 16'd1 : 16'd0);

	assign x_w    = CW'(pos_x);
	assign y_w    = CW'(pos_y);
	assign w_w    = CW'(box_width);
	assign h_w    = CW'(box_height);
	assign off_w  = CW'(cfg.column_offset);
	assign cols_w = CW'(cfg.panel_columns);
	assign one_w  = CW'(1);

	// Window words, wrapping at the coordinate width.
	always_comb begin
		case (orientation)
			lrfs_pkg::ORIENT_PORTRAIT: begin
				win_new[0] = off_w + x_w;
				win_new[1] = off_w + x_w + w_w - one_w;
				win_new[2] = y_w;
				win_new[3] = y_w + h_w - one_w;
			end
			lrfs_pkg::ORIENT_LANDSCAPE: begin
				win_new[0] = off_w + cols_w - y_w - h_w;
				win_new[1] = off_w + cols_w - y_w - one_w;
				win_new[2] = x_w;
				win_new[3] = x_w + w_w - one_w;
			end
			default: begin
				win_new[0] = '0;
				win_new[1] = '0;
				win_new[2] = '0;
				win_new[3] = '0;
			end
		endcase
	end

	// Byte for the current tick.
	always_comb begin
		res = '0;
		if (in_header) begin
			if (!header_step_q[0]) begin
				case (header_step_q)
					lrfs_pkg::STEP_COL_CMD:    res.serial_byte = cfg.column_set_code;
					lrfs_pkg::STEP_COL_START:  res.serial_byte = window_q[0][7:0];
					lrfs_pkg::STEP_COL_MARK0:  res.serial_byte = lrfs_pkg::FIXED_MARK;
					lrfs_pkg::STEP_COL_END:    res.serial_byte = window_q[1][7:0];
					lrfs_pkg::STEP_COL_MARK1:  res.serial_byte = lrfs_pkg::FIXED_MARK;
					lrfs_pkg::STEP_PAGE_CMD:   res.serial_byte = cfg.page_set_code;
					lrfs_pkg::STEP_PAGE_START: res.serial_byte = window_q[2][7:0];
					lrfs_pkg::STEP_PAGE_END:   res.serial_byte = window_q[3][7:0];
					default:                   res.serial_byte = cfg.ram_write_code;
				endcase
			end
			res.is_command = (header_step_q inside {lrfs_pkg::STEP_COL_CMD,
				lrfs_pkg::STEP_COL_CMD + 5'd1, lrfs_pkg::STEP_PAGE_CMD,
				lrfs_pkg::STEP_PAGE_CMD + 5'd1})
				|| (header_step_q >= lrfs_pkg::STEP_RAMWR);
			res.frame_end = (header_step_q == lrfs_pkg::STEP_RAMWR + 5'd1)
				&& (pixels_left_q == 16'd0);
		end else if (!low_byte_next_q) begin
			res.serial_byte = held_color_q[15:8];
		end else begin
			res.serial_byte = held_color_q[7:0];
			res.frame_end   = pixels_dec == 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			header_step_q   <= '0;
			pixels_left_q   <= '0;
			low_byte_next_q <= 1'b0;
		end else if (req) begin
			busy_q          <= 1'b1;
			header_step_q   <= (orientation <= lrfs_pkg::ORIENT_LANDSCAPE)
				? lrfs_pkg::STEP_COL_CMD : lrfs_pkg::STEP_RAMWR;
			pixels_left_q   <= 16'(box_width) * 16'(box_height);
			low_byte_next_q <= 1'b0;
		end else if (res_valid) begin
			if (res.frame_end)
				busy_q <= 1'b0;
			if (in_header) begin
				header_step_q <= header_step_q + 5'd1;
			end else begin
				low_byte_next_q <= !low_byte_next_q;
				if (low_byte_next_q)
					pixels_left_q <= pixels_dec;
			end
		end
	end

	// Payload latched on a request.
	always_ff @(posedge clk) begin
		if (req) begin
			held_color_q <= fill_color;
			for (int i = 0; i < 4; i++)
				window_q[i] <= win_new[i];
		end
	end

	`LRFS_ASSERT_IMPL(a_step_range, clk, arst_n, 1'b1, header_step_q <= lrfs_pkg::STEP_PIXELS)
	`LRFS_ASSERT_NEXT(a_end_idles, clk, arst_n, res_valid && res.frame_end, !busy_q)
	`LRFS_ASSERT_NEXT(a_req_busy, clk, arst_n, req, busy_q && !low_byte_next_q)

endmodule

>>> hdl/lrfs_out_buf.sv
// Two-word output buffer: result register plus skid register.
`include "lcd_rectangle_fill_sequencer_defines.svh"

module lrfs_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lrfs_pkg::result_t    push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lrfs_pkg::result_t    out_data
);

	logic              head_v_q;
	logic              skid_v_q;
	lrfs_pkg::result_t head_q;
	lrfs_pkg::result_t skid_q;
	logic              pop;

	assign pop       = head_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !head_v_q) begin
			// advance: skid word first, else the incoming word
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			if (skid_v_q)
				head_q <= skid_q;
			else if (push)
				head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`LRFS_ASSERT_IMPL(a_skid_has_head, clk, arst_n, skid_v_q, head_v_q)
	`LRFS_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !skid_v_q)
	`LRFS_ASSERT_NEXT(a_stall_fills, clk, arst_n, head_v_q && !out_ready && push, skid_v_q)

endmodule

>>> tb/fill_stream_checker.sv
// Byte stream predictor and comparator for the LCD window fill sequencer.
module fill_stream_checker
	import lrfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  box_width,
	input  logic [7:0]  box_height,
	input  logic [15:0] fill_color,
	input  logic [1:0]  orientation,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  serial_byte,
	input  logic        is_command,
	input  logic        frame_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          bytes_pending
);

	cfg_t        regs;
	logic        busy;
	logic [4:0]  step;
	logic [15:0] pix_left;
	logic        low_next;
	logic [7:0]  win [4];
	logic [15:0] color;
	logic [1:0]  orient;
	result_t     bytes_due [$];

	task automatic clear_state();
		regs = '{column_set_code: RST_COLUMN_SET_CODE, page_set_code: RST_PAGE_SET_CODE,
			ram_write_code: RST_RAM_WRITE_CODE, column_offset: RST_COLUMN_OFFSET,
			panel_columns: RST_PANEL_COLUMNS};
		busy = 1'b0;
		step = '0;
		pix_left = '0;
		low_next = 1'b0;
		foreach (win[i]) win[i] = '0;
		color = '0;
		orient = '0;
		bytes_due.delete();
		errors = 0;
		bytes_pending = 0;
	endtask

	// Latch the window; the offsets are taken from the registers as they stand now.
	task automatic latch_request(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h, input logic [15:0] c,
			input logic [1:0] o);
		if (busy)
			return;
		color = c;
		orient = o;
		foreach (win[i]) win[i] = '0;
		if (o == ORIENT_LANDSCAPE) begin
			win[0] = regs.column_offset + regs.panel_columns - y - h;
			win[1] = regs.column_offset + regs.panel_columns - y - 8'd1;
			win[2] = x;
			win[3] = x + w - 8'd1;
		end else if (o == ORIENT_PORTRAIT) begin
			win[0] = regs.column_offset + x;
			win[1] = regs.column_offset + x + w - 8'd1;
			win[2] = y;
			win[3] = y + h - 8'd1;
		end
		pix_left = 16'(w) * 16'(h);
		step = (o == ORIENT_PORTRAIT || o == ORIENT_LANDSCAPE) ? STEP_COL_CMD : STEP_RAMWR;
		low_next = 1'b0;
		busy = 1'b1;
	endtask

	task automatic next_stream_byte(output result_t r);
		r = '0;
		if (step < STEP_PIXELS) begin
			// odd steps carry the zero half of a word
			if (!step[0]) begin
				case (step)
					STEP_COL_CMD:                  r.serial_byte = regs.column_set_code;
					STEP_COL_START:                r.serial_byte = win[0];
					STEP_COL_MARK0, STEP_COL_MARK1: r.serial_byte = FIXED_MARK;
					STEP_COL_END:                  r.serial_byte = win[1];
					STEP_PAGE_CMD:                 r.serial_byte = regs.page_set_code;
					STEP_PAGE_START:               r.serial_byte = win[2];
					STEP_PAGE_END:                 r.serial_byte = win[3];
					default:                       r.serial_byte = regs.ram_write_code;
				endcase
			end
			r.is_command = (step <= STEP_COL_CMD + 5'd1) || (step == STEP_PAGE_CMD) ||
				(step == STEP_PAGE_CMD + 5'd1) || (step >= STEP_RAMWR);
			r.frame_end = (step == STEP_RAMWR + 5'd1) && (pix_left == '0);
			step = step + 5'd1;
		end else if (!low_next) begin
			low_next = 1'b1;
			r.serial_byte = color[15:8];
		end else begin
			low_next = 1'b0;
			if (pix_left != '0)
				pix_left = pix_left - 16'd1;
			r.serial_byte = color[7:0];
			r.frame_end = (pix_left == '0);
		end
		if (r.frame_end)
			busy = 1'b0;
	endtask

	function automatic void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual byte 0x%0h cmd %0b end %0b",
						$time, serial_byte, is_command, frame_end);
				end else begin
					want = bytes_due.pop_front();
					compare_field("serial_byte", want.serial_byte, serial_byte);
					compare_field("is_command", want.is_command, is_command);
					compare_field("frame_end", want.frame_end, frame_end);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLUMN_SET_CODE: regs.column_set_code = cfg_data;
					REG_PAGE_SET_CODE:   regs.page_set_code = cfg_data;
					REG_RAM_WRITE_CODE:  regs.ram_write_code = cfg_data;
					REG_COLUMN_OFFSET:   regs.column_offset = cfg_data;
					REG_PANEL_COLUMNS:   regs.panel_columns = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_REQUEST) begin
					latch_request(pos_x, pos_y, box_width, box_height, fill_color, orientation);
				end else if (busy) begin
					next_stream_byte(want);
					bytes_due.push_back(want);
				end
			end
			bytes_pending = bytes_due.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the LCD window fill sequencer.
module tb_top;
	import lrfs_pkg::*;

	localparam int PHASES = 6;
	localparam int ITEMS = 1950;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [1:0] ORIENT_NONE = 2'd2;
	localparam logic [1:0] ORIENT_NONE_ALT = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = MODE_TICK;
	logic [7:0]  pos_x = '0;
	logic [7:0]  pos_y = '0;
	logic [7:0]  box_width = '0;
	logic [7:0]  box_height = '0;
	logic [15:0] fill_color = '0;
	logic [1:0]  orientation = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  serial_byte;
	logic        is_command;
	logic        frame_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	int          errors;
	int          bytes_pending;
	int          cycles = 0;
	int          items_sent = 0;
	int          frames = 0;
	logic        steady_in = 1'b0;

	lcd_rectangle_fill_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
		.fill_color(fill_color), .orientation(orientation),
		.out_valid(out_valid), .out_ready(out_ready), .serial_byte(serial_byte),
		.is_command(is_command), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	fill_stream_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
		.fill_color(fill_color), .orientation(orientation),
		.out_valid(out_valid), .out_ready(out_ready), .serial_byte(serial_byte),
		.is_command(is_command), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .bytes_pending(bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly no gap, some short ones, a few long.
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: random stalls between runs of ready, some of them long.
	initial begin : ready_pattern
		int stall;
		@(posedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 6)) @(posedge clk);
		end
	end

	// Hold valid until the word is taken; leave valid high when no gap follows.
	task automatic send_word(input logic m, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h, input logic [15:0] c,
			input logic [1:0] o);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		pos_x <= x;
		pos_y <= y;
		box_width <= w;
		box_height <= h;
		fill_color <= c;
		orientation <= o;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		gap = steady_in ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic tick();
		send_word(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom), 2'($urandom));
	endtask

	task automatic stray_request();
		send_word(MODE_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom), 2'($urandom));
	endtask

	// One request and exactly the ticks that drain it; stray requests land while busy.
	task automatic run_frame(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
			input logic [7:0] h, input logic [15:0] c, input logic [1:0] o,
			input logic noisy);
		int n;
		n = ((o == ORIENT_PORTRAIT || o == ORIENT_LANDSCAPE) ?
			int'(STEP_PIXELS) : int'(STEP_PIXELS - STEP_RAMWR)) + 2 * int'(w) * int'(h);
		send_word(MODE_REQUEST, x, y, w, h, c, o);
		for (int k = 0; k < n; k++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				stray_request();
			tick();
		end
		frames++;
	endtask

	task automatic random_frame();
		int shape;
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] t;
		shape = $urandom_range(0, 99);
		if (shape < 60) begin
			w = 8'($urandom_range(0, 4));
			h = 8'($urandom_range(0, 4));
		end else if (shape < 75) begin
			w = 8'd0;
			h = 8'($urandom);
		end else if (shape < 90) begin
			w = 8'($urandom);
			h = 8'($urandom_range(0, 1));
		end else begin
			w = 8'($urandom_range(5, 12));
			h = 8'($urandom_range(5, 12));
		end
		if ($urandom_range(0, 1) == 1) begin
			t = w;
			w = h;
			h = t;
		end
		run_frame(8'($urandom), 8'($urandom), w, h, 16'($urandom), 2'($urandom), 1'b1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		int gap;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		gap = idle_cycles();
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] reg_value(input int phase);
		if (phase == 1)
			return 8'h00;
		if (phase == 2)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Drop valid, wait for every byte to come back, then let the pipe go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (bytes_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				// idle tick, empty bare frame at field extremes, 1x1 bare frame with a
				// request while busy, zero-height portrait window
				tick();
				run_frame(8'hFF, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, ORIENT_NONE, 1'b0);
				send_word(MODE_REQUEST, 8'h00, 8'h00, 8'h01, 8'h01, 16'h0000,
					ORIENT_NONE_ALT);
				tick();
				send_word(MODE_REQUEST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
					ORIENT_PORTRAIT);
				repeat (3) tick();
				run_frame(8'h00, 8'h00, 8'hFF, 8'h00, 16'h5AA5, ORIENT_PORTRAIT, 1'b0);
			end else begin
				settle();
				write_reg(REG_COLUMN_SET_CODE, reg_value(phase));
				write_reg(REG_PAGE_SET_CODE, reg_value(phase));
				write_reg(REG_RAM_WRITE_CODE, reg_value(phase));
				write_reg(REG_COLUMN_OFFSET, reg_value(phase));
				write_reg(REG_PANEL_COLUMNS, reg_value(phase));
				// indexes past the last register must change nothing
				write_reg(3'(REG_PANEL_COLUMNS) + 3'($urandom_range(1, 3)), 8'($urandom));
				cfg_valid <= 1'b0;
			end
			while (items_sent < (phase + 1) * ITEMS / PHASES) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) tick();
				steady_in = ($urandom_range(0, 3) == 0);
				random_frame();
			end
			steady_in = 1'b0;
		end
		settle();
		$display("Sent %0d words in %0d rectangles across %0d register settings.",
			items_sent, frames, PHASES);
		$display("Covered all orientations, empty and line windows, stray requests, idle ticks.");
		if (errors == 0 && bytes_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> lcd_rectangle_fill_sequencer.f
+incdir+hdl
hdl/lrfs_pkg.sv
hdl/lrfs_cfg_regs.sv
hdl/lrfs_core.sv
hdl/lrfs_out_buf.sv
hdl/lcd_rectangle_fill_sequencer.sv
tb/fill_stream_checker.sv
tb/tb_top.sv
